FILE: hw/rtl/lgs_pkg.sv
// shared types, codes and constants of the life generation step block
// no dependencies; every other file refers to it by scoped names
package lgs_pkg;

   // fixed field widths
   localparam int CFG_W     = 7;
   localparam int FUNC_W    = 2;
   localparam int COL_W     = 6;
   localparam int ROW_W     = 6;
   localparam int CSR_IDX_W = 1;

   // rows that a request can address
   localparam int FIELD_ROWS = 1 << ROW_W;

   // parameter defaults
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;

   // register reset values
   localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 7'd64;
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 7'd64;

   // neighbor counts of the b3/s23 rule
   localparam logic [3:0] NBR_BIRTH   = 4'd3;
   localparam logic [3:0] NBR_SURVIVE = 4'd2;

   // request queue between front and back
   localparam int Q_DEPTH = 2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } reg_idx_type;

   // operation codes, equal to the func field encoding
   typedef enum logic [FUNC_W-1:0] {
      OP_WRITE = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_ACCESS,
      BK_STEP
   } back_state_type;

   // classified request as it travels through the queue
   typedef struct packed {
      op_type           op;
      logic             in_area;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             cell_val;
   } entry_type;

   // grid dimensions in use
   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
   } dims_type;

   // clamp a dimension register to 1..limit
   function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] raw,
                                                input int limit);
      logic [CFG_W-1:0] res;
      res = raw;
      if (raw == '0) begin
         res = CFG_W'(1);
      end else if (int'(raw) > limit) begin
         res = CFG_W'(limit);
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/lgs_queue.sv
// short request queue between the front end and the back end
// depends on lgs_pkg for the entry type and depth
module lgs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lgs_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output lgs_pkg::entry_type pop_entry,
   output logic               empty
);

   localparam int QA = (lgs_pkg::Q_DEPTH > 1) ? $clog2(lgs_pkg::Q_DEPTH) : 1;

   lgs_pkg::entry_type entries_ff [lgs_pkg::Q_DEPTH];
   logic [QA-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QA-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QA:0]   count_ff, count_in;
   logic          do_push, do_pop;

   // status
   assign full      = (count_ff == (QA+1)'(lgs_pkg::Q_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = entries_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QA'(lgs_pkg::Q_DEPTH-1)) ? '0 : wr_ptr_ff + QA'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QA'(lgs_pkg::Q_DEPTH-1)) ? '0 : rd_ptr_ff + QA'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QA+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QA+1)'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: hw/rtl/lgs_front.sv
// front end: takes requests, classifies operation and bounds, feeds the queue
// depends on lgs_pkg for op codes, entry and dimension types
module lgs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [lgs_pkg::FUNC_W-1:0] req_func,
   input  logic [lgs_pkg::COL_W-1:0]  req_col,
   input  logic [lgs_pkg::ROW_W-1:0]  req_row,
   input  logic                      req_cell_in,
   input  lgs_pkg::dims_type         dims,
   input  logic                      clearing,
   input  logic                      q_full,
   output logic                      push,
   output lgs_pkg::entry_type        push_entry
);

   logic               front_valid_ff, front_valid_in;
   lgs_pkg::entry_type entry_ff, entry_in;
   lgs_pkg::entry_type classified;
   logic               accept;

   // handshake
   assign busy   = clearing || (front_valid_ff && q_full);
   assign accept = start && !busy;
   assign push   = front_valid_ff && !q_full;
   assign push_entry = entry_ff;

   // classify the request
   always_comb begin
      classified.col      = req_col;
      classified.row      = req_row;
      classified.cell_val = req_cell_in;
      classified.in_area  = (lgs_pkg::CFG_W'(req_col) < dims.width) &&
                            (lgs_pkg::CFG_W'(req_row) < dims.height);
      unique case (lgs_pkg::op_type'(req_func))
         lgs_pkg::OP_WRITE: classified.op = lgs_pkg::OP_WRITE;
         lgs_pkg::OP_STEP:  classified.op = lgs_pkg::OP_STEP;
         lgs_pkg::OP_READ:  classified.op = lgs_pkg::OP_READ;
         default:           classified.op = lgs_pkg::OP_NOP;
      endcase
   end

   // front stage next value
   always_comb begin
      front_valid_in = front_valid_ff;
      entry_in       = entry_ff;
      if (accept) begin
         front_valid_in = 1'b1;
         entry_in       = classified;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: hw/rtl/lgs_back.sv
// back end: grid memory, clearing pass, cell access and generation sweep
// depends on lgs_pkg for states, op codes, entry and dimension types
module lgs_back #(
   parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   input  lgs_pkg::dims_type  dims,
   input  logic               q_empty,
   input  lgs_pkg::entry_type pop_entry,
   output logic               pop,
   output logic               clearing,
   output logic               rsp_valid,
   output logic               rsp_cell_out
);

   localparam int ROW_AW    = $clog2(MAX_ROWS);
   localparam int COL_AW    = $clog2(MAX_COLS);
   localparam int LIVE_ROWS = (MAX_ROWS < lgs_pkg::FIELD_ROWS) ? MAX_ROWS
                                                               : lgs_pkg::FIELD_ROWS;
   localparam int CNT_W     = $clog2(LIVE_ROWS + 2);

   // grid store, one row per word
   logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
   logic [MAX_COLS-1:0] mem_rd_ff;

   lgs_pkg::back_state_type state_ff, state_in;
   logic [ROW_AW-1:0]   clr_ff, clr_in;
   logic [CNT_W-1:0]    step_cnt_ff, step_cnt_in;
   logic [MAX_COLS-1:0] above_ff, above_in;
   logic [MAX_COLS-1:0] mid_ff, mid_in;
   logic                rd_live_ff, rd_live_in;
   logic                mid_live_ff, mid_live_in;
   lgs_pkg::entry_type  cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_cell_ff, rsp_cell_in;

   logic                mem_rd_en;
   logic [ROW_AW-1:0]   mem_rd_addr;
   logic                mem_we;
   logic [ROW_AW-1:0]   mem_wa;
   logic [MAX_COLS-1:0] mem_wd;

   logic [MAX_COLS-1:0] col_mask;
   logic [MAX_COLS-1:0] below;
   logic [MAX_COLS+1:0] above_p, mid_p, below_p;
   logic [3:0]          nbr_cnt [MAX_COLS];
   logic [MAX_COLS-1:0] next_row;

   assign clearing     = (state_ff == lgs_pkg::BK_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;

   // columns in use
   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         col_mask[c] = (c < int'(dims.width));
      end
   end

   // row below the one being computed, dead when outside the area
   assign below = rd_live_ff ? (mem_rd_ff & col_mask) : '0;

   // b3/s23 rule over a three-row window
   assign above_p = {1'b0, above_ff, 1'b0};
   assign mid_p   = {1'b0, mid_ff, 1'b0};
   assign below_p = {1'b0, below, 1'b0};

   always_comb begin
      for (int c = 0; c < MAX_COLS; c++) begin
         nbr_cnt[c] = 4'(above_p[c]) + 4'(above_p[c+1]) + 4'(above_p[c+2]) +
                      4'(mid_p[c])                      + 4'(mid_p[c+2])   +
                      4'(below_p[c]) + 4'(below_p[c+1]) + 4'(below_p[c+2]);
         next_row[c] = col_mask[c] &&
                       ((nbr_cnt[c] == lgs_pkg::NBR_BIRTH) ||
                        (mid_ff[c] && (nbr_cnt[c] == lgs_pkg::NBR_SURVIVE)));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lgs_pkg::BK_CLEAR: begin
            if (clr_ff == ROW_AW'(MAX_ROWS-1)) begin
               state_in = lgs_pkg::BK_IDLE;
            end
         end
         lgs_pkg::BK_IDLE: begin
            if (!q_empty) begin
               unique case (pop_entry.op)
                  lgs_pkg::OP_WRITE,
                  lgs_pkg::OP_READ: begin
                     state_in = pop_entry.in_area ? lgs_pkg::BK_ACCESS : lgs_pkg::BK_IDLE;
                  end
                  lgs_pkg::OP_STEP: state_in = lgs_pkg::BK_STEP;
                  lgs_pkg::OP_NOP:  state_in = lgs_pkg::BK_IDLE;
               endcase
            end
         end
         lgs_pkg::BK_ACCESS: begin
            state_in = lgs_pkg::BK_IDLE;
         end
         lgs_pkg::BK_STEP: begin
            if (step_cnt_ff == CNT_W'(LIVE_ROWS+1)) begin
               state_in = lgs_pkg::BK_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      pop          = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = '0;
      clr_in       = clr_ff;
      step_cnt_in  = step_cnt_ff;
      above_in     = above_ff;
      mid_in       = mid_ff;
      rd_live_in   = rd_live_ff;
      mid_live_in  = mid_live_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_cell_in  = 1'b0;
      unique case (state_ff)
         // zero one row per cycle after reset
         lgs_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + ROW_AW'(1);
         end
         // take the next request from the queue
         lgs_pkg::BK_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cur_in = pop_entry;
               unique case (pop_entry.op)
                  lgs_pkg::OP_WRITE,
                  lgs_pkg::OP_READ: begin
                     if (pop_entry.in_area) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ROW_AW'(pop_entry.row);
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  lgs_pkg::OP_STEP: begin
                     step_cnt_in = '0;
                     above_in    = '0;
                     mid_in      = '0;
                     rd_live_in  = 1'b0;
                     mid_live_in = 1'b0;
                  end
                  lgs_pkg::OP_NOP: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         // row is in the read register: update a bit or return it
         lgs_pkg::BK_ACCESS: begin
            rsp_valid_in = 1'b1;
            if (cur_ff.op == lgs_pkg::OP_WRITE) begin
               mem_we = 1'b1;
               mem_wa = ROW_AW'(cur_ff.row);
               mem_wd = mem_rd_ff;
               mem_wd[cur_ff.col[COL_AW-1:0]] = cur_ff.cell_val;
            end else begin
               rsp_cell_in = mem_rd_ff[cur_ff.col[COL_AW-1:0]];
            end
         end
         // read row i, compute and write back row i-2
         lgs_pkg::BK_STEP: begin
            mem_rd_en   = (int'(step_cnt_ff) < LIVE_ROWS);
            mem_rd_addr = ROW_AW'(step_cnt_ff);
            rd_live_in  = (int'(step_cnt_ff) < LIVE_ROWS) &&
                          (int'(step_cnt_ff) < int'(dims.height));
            above_in    = mid_ff;
            mid_in      = below;
            mid_live_in = rd_live_ff;
            step_cnt_in = step_cnt_ff + CNT_W'(1);
            if (step_cnt_ff >= CNT_W'(2)) begin
               mem_we = 1'b1;
               mem_wa = ROW_AW'(step_cnt_ff - CNT_W'(2));
               mem_wd = mid_live_ff ? next_row : '0;
            end
            if (step_cnt_ff == CNT_W'(LIVE_ROWS+1)) begin
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgs_pkg::BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_cnt_ff <= step_cnt_in;
      above_ff    <= above_in;
      mid_ff      <= mid_in;
      rd_live_ff  <= rd_live_in;
      mid_live_ff <= mid_live_in;
      cur_ff      <= cur_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   // grid memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      if (mem_rd_en) begin
         mem_rd_ff <= grid_mem[mem_rd_addr];
      end
   end

endmodule

FILE: hw/rtl/life_generation_step_top.sv
// life generation step (b3/s23): cell write, cell read and generation step; other or out-of-area
// requests are answered without a memory access. a step sweeps L = min(MAX_ROWS, 64) rows.
// the back end takes a new request from the queue only once it is done with the last; a step
// sweeps the grid one row per cycle through the single memory read port.
// sync reset: registers to 64 x 64, then a clearing pass over all MAX_ROWS rows with busy high.
// responses are one-cycle strobes on rsp_valid and cannot be held off.
module life_generation_step_top #(
   parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lgs_pkg::FUNC_W-1:0]    req_func,
   input  logic [lgs_pkg::COL_W-1:0]     req_col,
   input  logic [lgs_pkg::ROW_W-1:0]     req_row,
   input  logic                          req_cell_in,
   output logic                          rsp_valid,
   output logic                          rsp_cell_out,
   input  logic                          csr_we,
   input  logic [lgs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lgs_pkg::CFG_W-1:0]     csr_wdata
);

   logic [lgs_pkg::CFG_W-1:0] grid_width_ff, grid_width_in;
   logic [lgs_pkg::CFG_W-1:0] grid_height_ff, grid_height_in;
   lgs_pkg::dims_type         dims;
   logic                      clearing;
   logic                      q_full, q_empty, push, pop;
   lgs_pkg::entry_type        push_entry, pop_entry;

   // configuration registers
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         unique case (lgs_pkg::reg_idx_type'(csr_index))
            lgs_pkg::REG_GRID_WIDTH:  grid_width_in  = csr_wdata;
            lgs_pkg::REG_GRID_HEIGHT: grid_height_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= lgs_pkg::GRID_WIDTH_RST;
         grid_height_ff <= lgs_pkg::GRID_HEIGHT_RST;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // dimensions in use, clamped to the array size
   assign dims.width  = lgs_pkg::sat_dim(grid_width_ff, MAX_COLS);
   assign dims.height = lgs_pkg::sat_dim(grid_height_ff, MAX_ROWS);

   // request intake
   lgs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_func    (req_func),
      .req_col     (req_col),
      .req_row     (req_row),
      .req_cell_in (req_cell_in),
      .dims        (dims),
      .clearing    (clearing),
      .q_full      (q_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // request queue
   lgs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   // execution
   lgs_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .dims         (dims),
      .q_empty      (q_empty),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .rsp_cell_out (rsp_cell_out)
   );

endmodule
